// ===== hdl/lsh_pkg.sv =====
// lsh-256 package: initial vector, step constants and permutation helpers
// used by lsh256_hash_core and lsh_step
package lsh_pkg;

  localparam int Rounds = 13;
  localparam int Steps = 2 * Rounds;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] vec_t;

  localparam vec_t Iv = '{
    32'he01afb41, 32'h47aa4484, 32'h138668c8, 32'h8051357a,
    32'hf2553fbe, 32'h5c2f2d95, 32'h2f74de54, 32'h105d5378,
    32'h7adbd553, 32'hb36061c4, 32'hb0f5a3c7, 32'h3304388d,
    32'h198e6b9d, 32'hb41443a8, 32'hfddce486, 32'h46a10f1f};

  localparam word_t [7:0] FirstConsts = '{
    32'h2eeb2642, 32'h8a9ba428, 32'h29e96ff2, 32'h2ceb7472,
    32'hcf778243, 32'h6f352943, 32'h6c1b10a2, 32'h917caf90};

  // groups 0 and 2 map 3,2,0,1; groups 1 and 3 map 3,0,1,2
  function automatic logic [3:0] exp_perm(input logic [3:0] k);
    logic [3:0] r;
    unique case (k[1:0])
      2'd0: r = {k[3:2], 2'd3};
      2'd1: r = {k[3:2], k[2] ? 2'd0 : 2'd2};
      2'd2: r = {k[3:2], k[2] ? 2'd1 : 2'd0};
      default: r = {k[3:2], k[2] ? 2'd2 : 2'd1};
    endcase
    return r;
  endfunction

  function automatic logic [3:0] word_perm(input logic [3:0] k);
    logic [3:0] r;
    unique case (k)
      4'd0: r = 4'd6;   4'd1: r = 4'd4;   4'd2: r = 4'd5;   4'd3: r = 4'd7;
      4'd4: r = 4'd12;  4'd5: r = 4'd15;  4'd6: r = 4'd14;  4'd7: r = 4'd13;
      4'd8: r = 4'd2;   4'd9: r = 4'd0;   4'd10: r = 4'd1;  4'd11: r = 4'd3;
      4'd12: r = 4'd8;  4'd13: r = 4'd11; 4'd14: r = 4'd10; default: r = 4'd9;
    endcase
    return r;
  endfunction

  function automatic word_t rotl(input word_t v, input logic [4:0] r);
    logic [63:0] d;
    d = {v, v} << r;
    return d[63:32];
  endfunction

endpackage

// ===== hdl/lsh_step.sv =====
// one lsh-256 mix step with word permutation, message expansion and
// constant update; depends on lsh_pkg
module lsh_step (
  input  lsh_pkg::vec_t            work,
  input  lsh_pkg::vec_t            msg_a,
  input  lsh_pkg::vec_t            msg_b,
  input  lsh_pkg::word_t [7:0]     consts,
  input  logic                     odd,
  output lsh_pkg::vec_t            work_next,
  output lsh_pkg::vec_t            msg_next,
  output lsh_pkg::word_t [7:0]     consts_next
);
  import lsh_pkg::*;

  localparam logic [4:0] AlphaEven = 5'd29;
  localparam logic [4:0] AlphaOdd = 5'd5;
  localparam logic [4:0] BetaEven = 5'd1;
  localparam logic [4:0] BetaOdd = 5'd17;

  vec_t mixed;
  vec_t x;

  always_comb begin
    logic [4:0] alpha;
    logic [4:0] beta;
    logic [4:0] gam;
    word_t lv;
    word_t rv;
    alpha = odd ? AlphaOdd : AlphaEven;
    beta = odd ? BetaOdd : BetaEven;
    for (int k = 0; k < 16; k++) begin
      x[k] = work[k] ^ msg_a[k];
    end
    mixed = x;
    for (int k = 0; k < 8; k++) begin
      gam = (k < 4) ? 5'(8 * k) : 5'(8 * (7 - k));
      lv = rotl(x[k] + x[k + 8], alpha) ^ consts[k];
      rv = rotl(x[k + 8] + lv, beta);
      lv = lv + rv;
      mixed[k] = lv;
      mixed[k + 8] = rotl(rv, gam);
    end
    for (int k = 0; k < 16; k++) begin
      work_next[k] = mixed[word_perm(4'(k))];
      msg_next[k] = msg_b[k] + msg_a[exp_perm(4'(k))];
    end
    for (int k = 0; k < 8; k++) begin
      consts_next[k] = consts[k] + rotl(consts[k], 5'd8);
    end
  end

endmodule

// ===== hdl/lsh256_hash_core.sv =====
// lsh-256-256 hash core top level: byte gathering, padding, step sequencer
// and digest output; depends on lsh_pkg and lsh_step
module lsh256_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  digest_index,
  output logic        digest_last
);
  import lsh_pkg::*;

  // Each input item is accepted in Idle, then its valid bytes (up to four)
  // are written into the block one per cycle, held while a compression runs,
  // and a closing pass through Bytes ends the item. Every 128 message bytes
  // start a compression: a load of the working set and 26 mix steps through
  // one shared step unit. A last word adds padding, one block word per cycle
  // from the current position to the end of the block, a final compression,
  // then eight digest items that wait on out_stall. in_stall is high whenever
  // the block is busy, until the eighth digest item is taken.

  typedef enum logic [2:0] {Idle, Bytes, Pad, Comp, Emit} state_t;

  state_t        state;
  word_t [31:0]  blk;
  logic [6:0]    fill;
  word_t         data;
  logic [2:0]    cnt;
  logic [1:0]    bidx;
  logic          fin;
  logic [4:0]    pad_idx;
  logic          pad_first;
  vec_t          chain;
  vec_t          work;
  vec_t          msg_a;
  vec_t          msg_b;
  word_t [7:0]   consts;
  logic [4:0]    step;
  logic          fin_comp;
  logic          comp_loaded;
  logic [2:0]    oidx;

  vec_t          work_next;
  vec_t          msg_next;
  word_t [7:0]   consts_next;

  lsh_step u_step (
    .work(work), .msg_a(msg_a), .msg_b(msg_b), .consts(consts),
    .odd(step[0]), .work_next(work_next), .msg_next(msg_next),
    .consts_next(consts_next)
  );

  assign in_stall = (state != Idle);
  assign digest_index = oidx;
  assign digest_last = (oidx == 3'd7);
  assign digest_word = chain[oidx] ^ chain[{1'b1, oidx}];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      fill <= '0;
      chain <= Iv;
      out_valid <= 1'b0;
      oidx <= '0;
      step <= '0;
      comp_loaded <= 1'b0;
    end else begin
      unique case (state)
        Idle: begin
          if (in_valid) begin
            data <= data_word;
            cnt <= (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
            bidx <= '0;
            fin <= last_word;
            state <= Bytes;
          end
        end
        Bytes: begin
          if (cnt == 3'd0) begin
            if (fin) begin
              pad_idx <= fill[6:2];
              pad_first <= 1'b1;
              state <= Pad;
            end else begin
              state <= Idle;
            end
          end else begin
            blk[fill[6:2]][8 * fill[1:0] +: 8] <= data[8 * bidx +: 8];
            bidx <= bidx + 2'd1;
            cnt <= cnt - 3'd1;
            fill <= fill + 7'd1;
            if (fill == 7'd127) begin
              state <= Comp;
              fin_comp <= 1'b0;
            end
          end
        end
        Pad: begin
          if (pad_first) begin
            blk[pad_idx] <= (fill[1:0] == 2'd0) ? 32'h80 :
                            (fill[1:0] == 2'd1) ? {16'h0, 8'h80, blk[pad_idx][7:0]} :
                            (fill[1:0] == 2'd2) ? {8'h0, 8'h80, blk[pad_idx][15:0]} :
                                                  {8'h80, blk[pad_idx][23:0]};
          end else begin
            blk[pad_idx] <= '0;
          end
          pad_first <= 1'b0;
          pad_idx <= pad_idx + 5'd1;
          if (pad_idx == 5'd31) begin
            state <= Comp;
            fin_comp <= 1'b1;
            fill <= '0;
          end
        end
        Comp: begin
          // compression runs after a setup step that loads the working set
          if (!comp_loaded) begin
            comp_loaded <= 1'b1;
            work <= chain;
            msg_a <= blk[15:0];
            msg_b <= blk[31:16];
            consts <= FirstConsts;
          end else begin
            work <= work_next;
            msg_a <= msg_b;
            msg_b <= msg_next;
            consts <= consts_next;
            if (step == 5'(Steps - 1)) begin
              step <= '0;
              comp_loaded <= 1'b0;
              for (int i = 0; i < 16; i++) begin
                chain[i] <= work_next[i] ^ msg_b[i];
              end
              if (fin_comp) begin
                state <= Emit;
                out_valid <= 1'b1;
                oidx <= '0;
              end else begin
                state <= Bytes;
              end
            end else begin
              step <= step + 5'd1;
            end
          end
        end
        Emit: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              out_valid <= 1'b0;
              chain <= Iv;
              state <= Idle;
            end
          end
        end
        default: begin
          state <= Idle;
        end
      endcase
    end
  end

endmodule
